/* hdl/lbp_pkg.sv */
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared constants for the streaming 3x3 local binary pattern block: field
// widths, register indexes and register reset values.
// ----------------------------------------------------------------------------
package lbp_pkg;

	// field widths
	localparam int PIX_W = 8;
	localparam int CFG_W = 12;
	localparam int ROW_W = 12;

	// default line buffer depth
	localparam int DEF_MAX_WIDTH = 2048;

	// configuration register indexes
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// configuration reset values
	localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
	localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 12'd480;

	// smallest frame edge
	localparam int MIN_EDGE = 3;

	// output payload
	typedef struct packed {
		logic [PIX_W-1:0] pattern_code;
		logic [PIX_W-1:0] gray_minus_code;
		logic             frame_last;
	} lbp_result_t;

endpackage

/* hdl/lbp_3x3_stream.sv */
// ----------------------------------------------------------------------------
// lbp_3x3_stream
// Streaming 3x3 local binary pattern over a raster pixel stream, with two
// line buffers, a 3x3 window and a result register.
// ----------------------------------------------------------------------------
// Accepted pixels wait in the stage 1 registers; results go to the output register.
// Throughput: one pixel per cycle, set by the registered line buffer read at
// acceptance and the one compare stage; only a held result stalls the input.
// Reset: counters, window and the output valid clear; registers return to 640 x 480.
// Line buffers are not cleared and need no clearing pass: no entry is used
// before the frame writes it.
module lbp_3x3_stream
	import lbp_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	// pixel requests
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [PIX_W-1:0] pixel,
	// result requests
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] pattern_code,
	output logic [PIX_W-1:0] gray_minus_code,
	output logic             frame_last,
	// configuration writes
	input  logic             cfg_write,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	// configuration registers
	logic [CFG_W-1:0] image_width_q;
	logic [CFG_W-1:0] image_height_q;

	// position counters
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	// stage 1
	logic             valid_s1;
	logic             has_result_s1;
	logic             last_s1;
	logic [CW-1:0]    col_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic [PIX_W-1:0] top_s1;
	logic [PIX_W-1:0] mid_s1;

	// line buffers
	logic [PIX_W-1:0] line_above_mem     [MAX_WIDTH];
	logic [PIX_W-1:0] line_two_above_mem [MAX_WIDTH];

	// window: 0..2 two columns back, 3..5 one column back (top, mid, bottom)
	logic [PIX_W-1:0] win_q [6];

	// output register
	logic        out_valid_q;
	lbp_result_t result_q;
	lbp_result_t result_d;

	logic             in_accept;
	logic             adv_s1;
	logic [CW-1:0]    col_last;
	logic [ROW_W-1:0] row_last;
	logic [31:0]      width_ext;
	logic             at_col_last;
	logic             at_row_last;
	logic [PIX_W-1:0] ctr;
	logic [PIX_W-1:0] code;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= RST_IMAGE_WIDTH;
			image_height_q <= RST_IMAGE_HEIGHT;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// last column and row, with width clamped to the buffer depth
	assign width_ext = 32'(image_width_q);
	always_comb begin
		if (width_ext < 32'(MIN_EDGE)) begin
			col_last = CW'(MIN_EDGE - 1);
		end else if (width_ext > 32'(MAX_WIDTH)) begin
			col_last = CW'(MAX_WIDTH - 1);
		end else begin
			col_last = CW'(width_ext - 32'd1);
		end
		if (image_height_q < ROW_W'(MIN_EDGE)) begin
			row_last = ROW_W'(MIN_EDGE - 1);
		end else begin
			row_last = image_height_q - ROW_W'(1);
		end
	end

	assign at_col_last = (col_q >= col_last);
	assign at_row_last = (row_q >= row_last);

	// handshake
	assign adv_s1    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;
	assign in_accept = in_valid && in_ready;

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			if (at_col_last) begin
				col_q <= '0;
				row_q <= at_row_last ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			has_result_s1 <= (row_q >= ROW_W'(2)) && (col_q >= CW'(2));
			last_s1       <= at_row_last && at_col_last;
			col_s1        <= col_q;
			pixel_s1      <= pixel;
		end
	end

	// row above: read at acceptance, written when the pixel leaves stage 1
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mid_s1 <= line_above_mem[col_q];
		end
		if (adv_s1) begin
			line_above_mem[col_s1] <= pixel_s1;
		end
	end

	// row two above
	always_ff @(posedge clk) begin
		if (in_accept) begin
			top_s1 <= line_two_above_mem[col_q];
		end
		if (adv_s1) begin
			line_two_above_mem[col_s1] <= mid_s1;
		end
	end

	// pattern compare against the centre
	assign ctr = win_q[4];
	always_comb begin
		code[0] = (ctr >= win_q[0]);
		code[1] = (ctr >= win_q[3]);
		code[2] = (ctr >= top_s1);
		code[3] = (ctr >= win_q[1]);
		code[4] = (ctr >= mid_s1);
		code[5] = (ctr >= win_q[2]);
		code[6] = (ctr >= win_q[5]);
		code[7] = (ctr >= pixel_s1);
		result_d.pattern_code    = code;
		result_d.gray_minus_code = (ctr >= code) ? ctr - code : code - ctr;
		result_d.frame_last      = last_s1;
	end

	// window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_s1;
			win_q[4] <= mid_s1;
			win_q[5] <= pixel_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= has_result_s1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_result_s1) begin
			result_q <= result_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign pattern_code    = result_q.pattern_code;
	assign gray_minus_code = result_q.gray_minus_code;
	assign frame_last      = result_q.frame_last;

	// checks

	// frame end brings both counters home
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && at_col_last && at_row_last) |=> (col_q == '0 && row_q == '0))
		else $error("counters not cleared at frame end");

	// a held stage 1 behind a stalled result blocks new pixels
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |-> !in_ready)
		else $error("pixel taken while pipeline stalled");

	// a pending result is never dropped without being taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("pending result lost");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams pixel frames of many shapes through lbp_3x3_stream, predicts the
// 3x3 local binary pattern of every interior centre alongside it, and checks
// each result in order, with random gaps on both request channels.
// ----------------------------------------------------------------------------
module testbench;
	import lbp_pkg::*;

	localparam int IDLE_LIMIT    = 4000;
	localparam int RANDOM_PIXELS = 1750;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int SHRINK_MAX    = 12;

	// row 0 tail, then a frame with a bright centre, then one with ties
	localparam logic [PIX_W-1:0] DIRECTED_PIXELS [16] = '{
		8'd7,
		8'd0, 8'd255, 8'd0,
		8'd255, 8'd255, 8'd0,
		8'd100, 8'd200, 8'd100,
		8'd200, 8'd100, 8'd50,
		8'd0, 8'd100, 8'd255
	};

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	// window, line buffers and position counters of the block, plus the codes
	// still to come out
	class lbp_tracker;
		logic [PIX_W-1:0] row_above [DEF_MAX_WIDTH];
		logic [PIX_W-1:0] row_two_above [DEF_MAX_WIDTH];
		logic [PIX_W-1:0] win [6];
		int unsigned col_pos;
		int unsigned row_pos;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		lbp_result_t pending_codes [$];
		int failures;

		function new();
			foreach (row_above[i]) begin
				row_above[i] = '0;
				row_two_above[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
			col_pos = 0;
			row_pos = 0;
			width_reg = RST_IMAGE_WIDTH;
			height_reg = RST_IMAGE_HEIGHT;
			failures = 0;
		endfunction

		function int unsigned eff_width();
			if (width_reg < MIN_EDGE) return MIN_EDGE;
			if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
			return 32'(width_reg);
		endfunction

		function int unsigned eff_height();
			if (height_reg < MIN_EDGE) return MIN_EDGE;
			return 32'(height_reg);
		endfunction

		function void set_reg(logic idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_IMAGE_WIDTH:  width_reg = val;
				REG_IMAGE_HEIGHT: height_reg = val;
			endcase
		endfunction

		function int pending();
			return pending_codes.size();
		endfunction

		function bit at_frame_start();
			return col_pos == 0 && row_pos == 0;
		endfunction

		// one accepted pixel request
		function void note_pixel(logic [PIX_W-1:0] px);
			int unsigned w;
			int unsigned h;
			int unsigned c;
			logic [PIX_W-1:0] top;
			logic [PIX_W-1:0] mid;
			logic [PIX_W-1:0] ctr;
			logic [PIX_W-1:0] code;
			lbp_result_t res;
			w = eff_width();
			h = eff_height();
			c = (col_pos < DEF_MAX_WIDTH) ? col_pos : DEF_MAX_WIDTH - 1;
			top = row_two_above[c];
			mid = row_above[c];
			if (row_pos >= 2 && col_pos >= 2) begin
				ctr = win[4];
				// weights 1,2,4 above, 8 left, 16 right, 32,64,128 below
				code = {ctr >= px, ctr >= win[5], ctr >= win[2], ctr >= mid,
					ctr >= win[1], ctr >= top, ctr >= win[3], ctr >= win[0]};
				res.pattern_code = code;
				res.gray_minus_code = (ctr >= code) ? ctr - code : code - ctr;
				res.frame_last = (row_pos >= h - 1) && (col_pos >= w - 1);
				pending_codes.push_back(res);
			end
			// shift the window one column and store the new column
			win[0] = win[3];
			win[1] = win[4];
			win[2] = win[5];
			win[3] = top;
			win[4] = mid;
			win[5] = px;
			row_two_above[c] = mid;
			row_above[c] = px;
			// raster position
			if (col_pos >= w - 1) begin
				col_pos = 0;
				if (row_pos >= h - 1) row_pos = 0;
				else row_pos++;
			end else begin
				col_pos++;
			end
		endfunction

		// one accepted result request
		function void check_result(logic [PIX_W-1:0] code, logic [PIX_W-1:0] diff,
			logic last);
			lbp_result_t want;
			if (pending_codes.size() == 0) begin
				$display("%0t: result with none expected: code %0d diff %0d last %0b",
					$time, code, diff, last);
				failures++;
				return;
			end
			want = pending_codes.pop_front();
			if (want.pattern_code !== code) begin
				$display("%0t: pattern_code expected %0d actual %0d",
					$time, want.pattern_code, code);
				failures++;
			end
			if (want.gray_minus_code !== diff) begin
				$display("%0t: gray_minus_code expected %0d actual %0d",
					$time, want.gray_minus_code, diff);
				failures++;
			end
			if (want.frame_last !== last) begin
				$display("%0t: frame_last expected %0b actual %0b",
					$time, want.frame_last, last);
				failures++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [PIX_W-1:0] pixel = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [PIX_W-1:0] pattern_code;
	logic [PIX_W-1:0] gray_minus_code;
	logic             frame_last;
	logic             cfg_write = 1'b0;
	logic             cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	lbp_tracker tracker;

	lbp_3x3_stream dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.pixel           (pixel),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pattern_code    (pattern_code),
		.gray_minus_code (gray_minus_code),
		.frame_last      (frame_last),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// offer one pixel request, with a random gap ahead of it
	task automatic send_pixel(input logic [PIX_W-1:0] px);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		pixel <= px;
		do @(posedge clk); while (!in_ready);
		tracker.note_pixel(px);
	endtask

	// wait for every pending result, then for anything still in flight
	task automatic settle();
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic [CFG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		tracker.set_reg(idx, val);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_idle_pct = 57;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct = 0;
				recv_stall_pct = 57;
			end
			IDLE_BOTH: begin
				send_idle_pct = 16;
				recv_stall_pct = 16;
			end
		endcase
	endtask

	// mostly uniform, with extremes and a narrow band for ties
	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return PIX_W'($urandom_range(100, 103));
			default: return PIX_W'($urandom);
		endcase
	endfunction

	// result requests, random stalls and the long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				tracker.check_result(pattern_code, gray_minus_code, frame_last);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// watchdog on cycles without any request moving
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	// stimulus
	initial begin
		int sent;
		int frame_idx;
		int in_frame;
		int cut_at;
		int shrink_at;
		int unsigned shrink_max;
		logic [CFG_W-1:0] w_val;
		logic [CFG_W-1:0] h_val;
		tracker = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// start of row 0 at the reset shape
		send_pixel(8'd255);
		send_pixel(8'd0);
		send_pixel(8'd255);
		send_pixel(8'd0);
		in_valid <= 1'b0;
		settle();
		// shrink to 3 x 3 mid-row: column 4 wraps after the next pixel
		write_cfg(REG_IMAGE_WIDTH, 12'd3);
		write_cfg(REG_IMAGE_HEIGHT, 12'd3);
		foreach (DIRECTED_PIXELS[i]) send_pixel(DIRECTED_PIXELS[i]);

		// random frames
		sent = 0;
		frame_idx = 0;
		while (sent < RANDOM_PIXELS) begin
			cut_at = -1;
			shrink_at = -1;
			if (frame_idx % 2 == 0 || frame_idx == 7) begin
				in_valid <= 1'b0;
				settle();
				case ($urandom_range(0, 9))
					0: begin
						w_val = CFG_W'($urandom_range(0, 2));
						h_val = CFG_W'($urandom_range(3, 6));
					end
					1: begin
						w_val = CFG_W'($urandom_range(3, 10));
						h_val = CFG_W'($urandom_range(0, 2));
					end
					2: begin
						// tall frame, cut short by a height write mid-frame
						w_val = CFG_W'($urandom_range(3, 6));
						h_val = $urandom_range(0, 1) ? '1 : CFG_W'($urandom_range(2048, 4094));
						cut_at = $urandom_range(10, 40);
					end
					3: begin
						w_val = CFG_W'($urandom_range(16, 64));
						h_val = CFG_W'($urandom_range(3, 4));
					end
					4: begin
						w_val = CFG_W'($urandom_range(4, 12));
						h_val = CFG_W'($urandom_range(3, 8));
						shrink_at = $urandom_range(1, 3 * w_val);
					end
					default: begin
						w_val = CFG_W'($urandom_range(3, 12));
						h_val = CFG_W'($urandom_range(3, 8));
					end
				endcase
				// dense frame ahead of the hold-off, one frame set past the
				// buffer depth and narrowed within its first row
				if (frame_idx == 2) begin
					w_val = 12'd8;
					h_val = 12'd8;
					cut_at = -1;
					shrink_at = -1;
				end
				if (frame_idx == 6) begin
					w_val = '1;
					h_val = 12'd3;
					cut_at = -1;
					shrink_at = $urandom_range(8, 40);
				end
				write_cfg(REG_IMAGE_WIDTH, w_val);
				write_cfg(REG_IMAGE_HEIGHT, h_val);
			end
			set_idle(idle_mode_t'(frame_idx % 4));
			if (frame_idx == 3) hold_cycles = HOLD_CYCLES;
			in_frame = 0;
			do begin
				send_pixel(rand_pixel());
				sent++;
				in_frame++;
				// register writes inside the frame; width only ever shrinks here
				if ((in_frame == cut_at || in_frame == shrink_at) &&
					!tracker.at_frame_start()) begin
					in_valid <= 1'b0;
					settle();
					shrink_max = tracker.eff_width();
					if (shrink_max > SHRINK_MAX) shrink_max = SHRINK_MAX;
					if (in_frame == cut_at)
						write_cfg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 8)));
					else
						write_cfg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(0, shrink_max)));
				end
			end while (!tracker.at_frame_start());
			frame_idx++;
		end

		// drain
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/lbp_pkg.sv
hdl/lbp_3x3_stream.sv
verif/testbench.sv
